// File: design/rotary_encoder_button_qualifier_assert.svh
// Assertion macros for the rotary encoder button qualifier.
// Used by the checker module; needs nothing else.
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_ASSERT_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define REBQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define REBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define REBQ_ASSERT_LAT2(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// File: design/rebq_pkg.sv
// Shared types and constants of the rotary encoder button qualifier.
// No dependencies; the interfaces, the top level and the checker import this package.
`timescale 1ns / 1ps

package rebq_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DELTA_W    = 16;
    localparam int unsigned SPEED_W    = 3;
    localparam int unsigned DEB_W      = 8;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT_DIR = 3'd0,
        CFG_DEBOUNCE   = 3'd1,
        CFG_HOLD_TIME  = 3'd2,
        CFG_REPEAT     = 3'd3,
        CFG_ACCEL      = 3'd4,
        CFG_MAX_SPEED  = 3'd5
    } t_cfg_index;

    // Latched button events.
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_HOLD   = 2'd2,
        EV_REPEAT = 2'd3
    } t_event;

    // Reset values of the configuration registers.
    localparam logic               RST_INVERT_DIR = 1'b0;
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE   = 8'd20;
    localparam logic [MS_W-1:0]    RST_HOLD_TIME  = 16'd800;
    localparam logic [MS_W-1:0]    RST_REPEAT     = 16'd180;
    localparam logic [MS_W-1:0]    RST_ACCEL      = 16'd70;
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED  = 3'd4;

    // Input word: one pin sample with its timestamp and take flags.
    typedef struct packed {
        logic              pin_a;
        logic              pin_b;
        logic              pin_button;
        logic [TIME_W-1:0] time_ms;
        logic              take_delta;
        logic              take_event;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_value;
        logic [1:0]                event_code;
    } t_out_word;

endpackage

// File: design/rebq_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on rebq_pkg for the payload types.
`timescale 1ns / 1ps

interface rebq_in_if import rebq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rebq_out_if import rebq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/rotary_encoder_button_qualifier.sv
// Rotary encoder decoder with step acceleration and a debounced push button.
// Depends on rebq_pkg and the channel interfaces in rebq_if.sv.
//
// Usage:
// - i_in_ch carries one sample word per handshake: encoder pins A and B, the
//   active-low button pin, a millisecond timestamp and the two take flags.
// - o_out_ch returns one result word per sample: the accumulated delta after
//   that sample and the latched button event.
// - i_cfg_we / i_cfg_index / i_cfg_wdata write the six settings registers;
//   write them only while no sample is in flight.
// Path: a word goes into an input register, then into the result register
//   once that register is free or its word is being taken.
// Throughput: one word per cycle while results are taken; all per-sample
//   work is one pass of short logic, deepest at the 32-bit timestamp subtractions.
// Reset (synchronous, active low) empties both stages, returns the settings
//   to their defaults, clears delta and button state and sets speed factor to 1.
// Stall: a held result stays stable on o_out_ch; one more word can still be
//   taken into the input register, after which i_in_ch.ready drops until
//   the result is taken.
`timescale 1ns / 1ps

module rotary_encoder_button_qualifier
    import rebq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rebq_in_if.sink               i_in_ch,
    rebq_out_if.source            o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Settings registers.
    logic               r_invert_dir;
    logic [DEB_W-1:0]   r_debounce;
    logic [MS_W-1:0]    r_hold_time;
    logic [MS_W-1:0]    r_repeat;
    logic [MS_W-1:0]    r_accel;
    logic [SPEED_W-1:0] r_max_speed;

    // Pipeline registers.
    logic      r_s1_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    // Decoder and button state.
    logic               r_last_a;
    logic [SPEED_W-1:0] r_speed_factor;
    logic [TIME_W-1:0]  r_last_step_time;
    logic [DELTA_W-1:0] r_delta;
    logic               r_button_state;
    logic [DEB_W-1:0]   r_deb_count;
    logic [TIME_W-1:0]  r_press_time;
    logic               r_hold_done;
    logic [TIME_W-1:0]  r_last_repeat;
    t_event             r_pending;

    // Next values.
    logic [SPEED_W-1:0] n_speed_factor;
    logic [TIME_W-1:0]  n_last_step_time;
    logic [DELTA_W-1:0] n_delta;
    logic               n_button_state;
    logic [DEB_W-1:0]   n_deb_count;
    logic [TIME_W-1:0]  n_press_time;
    logic               n_hold_done;
    logic [TIME_W-1:0]  n_last_repeat;
    t_event             n_pending;
    t_out_word          n_out;

    // Intermediate terms.
    logic               s1_adv;
    logic [TIME_W-1:0]  now;
    logic               step_en;
    logic               step_up;
    logic               step_quick;
    logic [SPEED_W-1:0] speed_top;
    logic [SPEED_W:0]   speed_inc;
    logic [TIME_W-1:0]  step_gap;
    logic [DELTA_W-1:0] step_weight;
    logic [DELTA_W-1:0] delta_upd;
    logic               pressed_now;
    logic               btn_differs;
    logic [DEB_W-1:0]   deb_next;
    logic               btn_accept;
    logic               press_start;
    logic [TIME_W-1:0]  held_gap;
    logic [TIME_W-1:0]  repeat_gap;
    t_event             ev_upd;

    // Handshake: stage 1 advances whenever the result register is free or taken.
    assign s1_adv         = r_s1_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !r_s1_valid || s1_adv;
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    // Rotation: one step per change of pin A, weighted by the speed factor.
    always_comb begin
        now         = r_in.time_ms;
        step_en     = r_in.pin_a != r_last_a;
        step_up     = (r_in.pin_a == r_in.pin_b) ^ r_invert_dir;
        speed_top   = (r_max_speed == '0) ? SPEED_W'(1) : r_max_speed;
        speed_inc   = {1'b0, r_speed_factor} + (SPEED_W+1)'(1);
        step_gap    = now - r_last_step_time;
        step_quick  = step_gap < {{(TIME_W-MS_W){1'b0}}, r_accel};

        n_speed_factor   = r_speed_factor;
        n_last_step_time = r_last_step_time;
        if (step_en) begin
            if (step_quick) begin
                n_speed_factor = (speed_inc >= {1'b0, speed_top}) ?
                                 speed_top : speed_inc[SPEED_W-1:0];
            end else begin
                n_speed_factor = SPEED_W'(1);
            end
            n_last_step_time = now;
        end

        step_weight = {{(DELTA_W-SPEED_W){1'b0}}, n_speed_factor};
        if (!step_en) begin
            delta_upd = r_delta;
        end else if (step_up) begin
            delta_upd = r_delta + step_weight;
        end else begin
            delta_upd = r_delta - step_weight;
        end
    end

    // Button: debounce, then click, hold and repeat timing.
    always_comb begin
        pressed_now = !r_in.pin_button;
        btn_differs = pressed_now != r_button_state;
        deb_next    = (r_deb_count == {DEB_W{1'b1}}) ? r_deb_count :
                      r_deb_count + DEB_W'(1);
        btn_accept  = btn_differs && (deb_next >= r_debounce);
        press_start = btn_accept && pressed_now;

        n_button_state = btn_accept ? pressed_now : r_button_state;
        n_deb_count    = (btn_differs && !btn_accept) ? deb_next : '0;
        n_press_time   = press_start ? now : r_press_time;
        n_hold_done    = press_start ? 1'b0 : r_hold_done;
        n_last_repeat  = press_start ? now : r_last_repeat;

        ev_upd = r_pending;
        if (btn_accept && !pressed_now && !r_hold_done) begin
            ev_upd = EV_CLICK;
        end

        // A press accepted in this sample has zero elapsed time.
        held_gap   = press_start ? '0 : now - r_press_time;
        repeat_gap = now - r_last_repeat;

        if (n_button_state) begin
            if (!n_hold_done && held_gap >= {{(TIME_W-MS_W){1'b0}}, r_hold_time}) begin
                n_hold_done   = 1'b1;
                ev_upd        = EV_HOLD;
                n_last_repeat = now;
            end else if (n_hold_done &&
                         repeat_gap >= {{(TIME_W-MS_W){1'b0}}, r_repeat}) begin
                n_last_repeat = now;
                ev_upd        = EV_REPEAT;
            end
        end
    end

    // Result word and the take flags.
    always_comb begin
        n_out.delta_value = delta_upd;
        n_out.event_code  = ev_upd;
        n_delta           = r_in.take_delta ? '0 : delta_upd;
        n_pending         = r_in.take_event ? EV_NONE : ev_upd;
    end

    // Control, settings and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_invert_dir     <= RST_INVERT_DIR;
            r_debounce       <= RST_DEBOUNCE;
            r_hold_time      <= RST_HOLD_TIME;
            r_repeat         <= RST_REPEAT;
            r_accel          <= RST_ACCEL;
            r_max_speed      <= RST_MAX_SPEED;
            r_last_a         <= 1'b1;
            r_speed_factor   <= SPEED_W'(1);
            r_last_step_time <= '0;
            r_delta          <= '0;
            r_button_state   <= 1'b0;
            r_deb_count      <= '0;
            r_press_time     <= '0;
            r_hold_done      <= 1'b0;
            r_last_repeat    <= '0;
            r_pending        <= EV_NONE;
        end else begin
            if (i_in_ch.ready) begin
                r_s1_valid <= i_in_ch.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_INVERT_DIR: r_invert_dir <= i_cfg_wdata[0];
                    CFG_DEBOUNCE:   r_debounce   <= i_cfg_wdata[DEB_W-1:0];
                    CFG_HOLD_TIME:  r_hold_time  <= i_cfg_wdata[MS_W-1:0];
                    CFG_REPEAT:     r_repeat     <= i_cfg_wdata[MS_W-1:0];
                    CFG_ACCEL:      r_accel      <= i_cfg_wdata[MS_W-1:0];
                    CFG_MAX_SPEED:  r_max_speed  <= i_cfg_wdata[SPEED_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (s1_adv) begin
                r_last_a         <= r_in.pin_a;
                r_speed_factor   <= n_speed_factor;
                r_last_step_time <= n_last_step_time;
                r_delta          <= n_delta;
                r_button_state   <= n_button_state;
                r_deb_count      <= n_deb_count;
                r_press_time     <= n_press_time;
                r_hold_done      <= n_hold_done;
                r_last_repeat    <= n_last_repeat;
                r_pending        <= n_pending;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in <= i_in_ch.data;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

endmodule

// File: design/rebq_checker.sv
// Port-level checks for the rotary encoder button qualifier, bound to the top level.
// Depends on rebq_pkg and rotary_encoder_button_qualifier_assert.svh.
`timescale 1ns / 1ps
`include "rotary_encoder_button_qualifier_assert.svh"

module rebq_checker
    import rebq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    // A stalled result word stays offered.
    `REBQ_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result word dropped while stalled")

    // A stalled result word does not change.
    `REBQ_ASSERT_NEXT(a_out_data_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data), "result word changed while stalled")

    // An empty result register never holds off the input channel.
    `REBQ_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input blocked with no result pending")

    // Every accepted word is followed by a result on offer once it has passed the input register.
    `REBQ_ASSERT_LAT2(a_result_latency, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "no result two cycles after an accepted word")

endmodule

bind rotary_encoder_button_qualifier rebq_checker u_rebq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_data  (o_out_ch.data)
);

// File: test/testbench.sv
// Testbench for the rotary encoder button qualifier: a scoreboard predicts each result word.
// Directed and random pin samples are driven under many register settings and idle patterns.
// Depends on rebq_pkg, the channel interfaces in rebq_if.sv and the design top level.
`timescale 1ns / 1ps

module testbench;
    import rebq_pkg::*;

    // Predicts the result word of every accepted sample and checks what the block returns.
    class qualifier_scoreboard;
        // Copy of the settings registers.
        logic               cfg_invert;
        logic [DEB_W-1:0]   cfg_debounce;
        logic [MS_W-1:0]    cfg_hold;
        logic [MS_W-1:0]    cfg_repeat;
        logic [MS_W-1:0]    cfg_accel;
        logic [SPEED_W-1:0] cfg_max_speed;

        // Copy of the decoder and button state.
        logic                      last_a;
        logic [SPEED_W-1:0]        speed;
        logic [TIME_W-1:0]         last_step_ms;
        logic signed [DELTA_W-1:0] delta;
        logic                      btn_down;
        logic [DEB_W-1:0]          deb_count;
        logic [TIME_W-1:0]         press_ms;
        logic                      hold_done;
        logic [TIME_W-1:0]         last_repeat_ms;
        t_event                    pending_ev;

        t_out_word awaited_reports[$];
        int        mismatches;
        int        checked;

        function new();
            cfg_invert     = RST_INVERT_DIR;
            cfg_debounce   = RST_DEBOUNCE;
            cfg_hold       = RST_HOLD_TIME;
            cfg_repeat     = RST_REPEAT;
            cfg_accel      = RST_ACCEL;
            cfg_max_speed  = RST_MAX_SPEED;
            last_a         = 1'b1;
            speed          = 3'd1;
            last_step_ms   = '0;
            delta          = '0;
            btn_down       = 1'b0;
            deb_count      = '0;
            press_ms       = '0;
            hold_done      = 1'b0;
            last_repeat_ms = '0;
            pending_ev     = EV_NONE;
            mismatches     = 0;
            checked        = 0;
        endfunction

        function void set_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_INVERT_DIR: cfg_invert    = value[0];
                CFG_DEBOUNCE:   cfg_debounce  = value[DEB_W-1:0];
                CFG_HOLD_TIME:  cfg_hold      = value[MS_W-1:0];
                CFG_REPEAT:     cfg_repeat    = value[MS_W-1:0];
                CFG_ACCEL:      cfg_accel     = value[MS_W-1:0];
                CFG_MAX_SPEED:  cfg_max_speed = value[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        // Rotation, then debounce, then hold and repeat timing; take flags clear last.
        function void note_sample(t_in_word w);
            logic [SPEED_W-1:0] top;
            logic [TIME_W-1:0]  gap;
            logic               up;
            logic               pressed;
            t_out_word          report;

            top = (cfg_max_speed == '0) ? 3'd1 : cfg_max_speed;
            if (w.pin_a != last_a) begin
                up = (w.pin_a == w.pin_b) ^ cfg_invert;
                gap = w.time_ms - last_step_ms;
                if (gap < {16'd0, cfg_accel}) begin
                    if (int'(speed) + 1 >= int'(top)) speed = top;
                    else speed = speed + 3'd1;
                end else begin
                    speed = 3'd1;
                end
                last_step_ms = w.time_ms;
                if (up) delta = delta + {13'd0, speed};
                else delta = delta - {13'd0, speed};
                last_a = w.pin_a;
            end

            // Debounce counts consecutive samples that differ from the accepted level.
            pressed = ~w.pin_button;
            if (pressed != btn_down) begin
                if (deb_count != 8'd255) deb_count = deb_count + 8'd1;
                if (deb_count >= cfg_debounce) begin
                    btn_down = pressed;
                    deb_count = '0;
                    if (btn_down) begin
                        press_ms = w.time_ms;
                        hold_done = 1'b0;
                        last_repeat_ms = w.time_ms;
                    end else if (!hold_done) begin
                        pending_ev = EV_CLICK;
                    end
                end
            end else begin
                deb_count = '0;
            end

            // Hold fires once per press, repeats follow while the button stays down.
            if (btn_down) begin
                if (!hold_done && (w.time_ms - press_ms) >= {16'd0, cfg_hold}) begin
                    hold_done = 1'b1;
                    pending_ev = EV_HOLD;
                    last_repeat_ms = w.time_ms;
                end else if (hold_done &&
                             (w.time_ms - last_repeat_ms) >= {16'd0, cfg_repeat}) begin
                    last_repeat_ms = w.time_ms;
                    pending_ev = EV_REPEAT;
                end
            end

            report.delta_value = delta;
            report.event_code  = pending_ev;
            awaited_reports.push_back(report);

            if (w.take_delta) delta = '0;
            if (w.take_event) pending_ev = EV_NONE;
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;

            checked++;
            if (awaited_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %0d: delta %0d event %0d",
                             checked, got.delta_value, got.event_code);
                return;
            end
            want = awaited_reports.pop_front();
            if (got.delta_value !== want.delta_value || got.event_code !== want.event_code) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch on word %0d: delta expected %0d got %0d, ",
                              "event expected %0d got %0d"},
                             checked, want.delta_value, got.delta_value,
                             want.event_code, got.event_code);
            end
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    rebq_in_if  in_ch ();
    rebq_out_if out_ch ();

    rotary_encoder_button_qualifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    qualifier_scoreboard book = new();

    // Idle pattern of both sides and the long receiver hold-off.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_off_left  = 0;

    // Stimulus generator state: encoder position, button level and time base.
    logic [1:0]        enc_pos     = 2'd2;
    int                spin_left   = 0;
    logic              spin_up     = 1'b1;
    logic              spin_quick  = 1'b0;
    logic              btn_level   = 1'b1;
    int                btn_left    = 0;
    int                bounce_left = 0;
    int unsigned       tick_max    = 20;
    logic [TIME_W-1:0] now_ms      = '0;
    int unsigned       cur_deb     = 20;
    int unsigned       cur_accel   = 70;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: check every accepted word, then pick the next ready level.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                book.check_result(out_ch.data);
            if (hold_off_left > 0) begin
                hold_off_left = hold_off_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one sample word and hold it until the block takes it.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        book.note_sample(w);
    endtask

    task automatic send_fields(input logic a, input logic b, input logic btn,
                               input logic [TIME_W-1:0] t, input logic td, input logic te);
        t_in_word w;
        w.pin_a      = a;
        w.pin_b      = b;
        w.pin_button = btn;
        w.time_ms    = t;
        w.take_delta = td;
        w.take_event = te;
        send_word(w);
    endtask

    // Lower valid and wait until every result is back and the pipeline is empty.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        book.set_register(idx, value);
    endtask

    task automatic apply_settings(input logic inv, input logic [7:0] deb,
                                  input logic [15:0] hold, input logic [15:0] rep,
                                  input logic [15:0] acc, input logic [2:0] max_spd);
        write_register(CFG_INVERT_DIR, {15'd0, inv});
        write_register(CFG_DEBOUNCE,   {8'd0, deb});
        write_register(CFG_HOLD_TIME,  hold);
        write_register(CFG_REPEAT,     rep);
        write_register(CFG_ACCEL,      acc);
        write_register(CFG_MAX_SPEED,  {13'd0, max_spd});
        i_cfg_we <= 1'b0;
        cur_deb   = (deb == 8'd0) ? 1 : 32'(deb);
        cur_accel = 32'(acc);
    endtask

    // Quadrature spins and bouncing button presses with random content, plus some noise.
    task automatic send_random_samples(input int count);
        t_in_word    w;
        int unsigned span;
        for (int n = 0; n < count; n++) begin
            if (spin_left == 0 && $urandom_range(99) < 30) begin
                spin_left  = $urandom_range(12, 1);
                spin_up    = 1'($urandom_range(1));
                spin_quick = 1'($urandom_range(1));
            end
            if (spin_left > 0) begin
                enc_pos   = spin_up ? enc_pos + 2'd1 : enc_pos - 2'd1;
                spin_left = spin_left - 1;
            end
            // A new button level starts: presses outlast the debounce count.
            if (btn_left == 0) begin
                btn_level   = ~btn_level;
                bounce_left = $urandom_range(3);
                if (btn_level == 1'b0) btn_left = cur_deb + $urandom_range(40);
                else btn_left = $urandom_range(cur_deb + 20, 1);
                case ($urandom_range(3))
                    0: tick_max = 2;
                    1: tick_max = 20;
                    2: tick_max = 300;
                    default: tick_max = 3000;
                endcase
            end
            btn_left = btn_left - 1;

            w.pin_a      = enc_pos[1];
            w.pin_b      = enc_pos[1] ^ enc_pos[0];
            w.pin_button = btn_level;
            if (bounce_left > 0) begin
                bounce_left = bounce_left - 1;
                if ($urandom_range(1)) w.pin_button = ~btn_level;
            end
            span = (spin_left > 0 && spin_quick) ? cur_accel / 2 : tick_max;
            if ($urandom_range(99) < 2) span = 70000;
            now_ms       = now_ms + $urandom_range(span, 0);
            w.time_ms    = now_ms;
            w.take_delta = ($urandom_range(99) < 25);
            w.take_event = ($urandom_range(99) < 30);

            // Noise: pins at random, now and then a timestamp anywhere.
            if ($urandom_range(99) < 5) begin
                w.pin_a      = 1'($urandom_range(1));
                w.pin_b      = 1'($urandom_range(1));
                w.pin_button = 1'($urandom_range(1));
                if ($urandom_range(4) == 0) begin
                    now_ms    = $urandom;
                    w.time_ms = now_ms;
                end
            end
            send_word(w);
        end

        // Close with a quick spin so the next setting starts with a high speed factor.
        for (int n = 0; n < 8; n++) begin
            enc_pos = enc_pos + 2'd1;
            now_ms  = now_ms + 1;
            send_fields(enc_pos[1], enc_pos[1] ^ enc_pos[0], btn_level, now_ms, 1'b0, 1'b0);
        end
    endtask

    task automatic run_phase(input logic inv, input logic [7:0] deb, input logic [15:0] hold,
                             input logic [15:0] rep, input logic [15:0] acc,
                             input logic [2:0] max_spd, input int unsigned idle_pct,
                             input int unsigned stall_pct, input int count);
        drain_block();
        apply_settings(inv, deb, hold, rep, acc, max_spd);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random_samples(count);
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_wdata  = '0;
        i_rst_n      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples: step directions and speeds, press, hold, repeat, click,
        // timestamp wrap and both take flags.
        apply_settings(1'b0, 8'd1, 16'd3, 16'd2, 16'd70, 3'd7);
        send_fields(1'b1, 1'b1, 1'b1, 32'd0,   1'b0, 1'b0);
        send_fields(1'b0, 1'b0, 1'b1, 32'd5,   1'b0, 1'b0);
        send_fields(1'b1, 1'b0, 1'b1, 32'd10,  1'b0, 1'b0);
        send_fields(1'b0, 1'b1, 1'b1, 32'd15,  1'b1, 1'b0);
        send_fields(1'b1, 1'b1, 1'b1, 32'd16,  1'b0, 1'b0);
        send_fields(1'b0, 1'b0, 1'b1, 32'd200, 1'b0, 1'b0);
        send_fields(1'b0, 1'b0, 1'b0, 32'd201, 1'b0, 1'b0);
        send_fields(1'b0, 1'b0, 1'b0, 32'd204, 1'b0, 1'b0);
        send_fields(1'b0, 1'b0, 1'b0, 32'd206, 1'b0, 1'b1);
        send_fields(1'b0, 1'b0, 1'b1, 32'd207, 1'b0, 1'b0);
        send_fields(1'b0, 1'b0, 1'b0, 32'd208, 1'b0, 1'b0);
        send_fields(1'b0, 1'b0, 1'b1, 32'd209, 1'b0, 1'b1);
        send_fields(1'b1, 1'b0, 1'b1, 32'hFFFF_FFF0, 1'b0, 1'b0);
        send_fields(1'b0, 1'b1, 1'b1, 32'h0000_0005, 1'b0, 1'b0);
        send_fields(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_fields(1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0);
        send_fields(1'b1, 1'b1, 1'b0, 32'h0000_0002, 1'b1, 1'b1);
        send_fields(1'b0, 1'b0, 1'b0, 32'h0000_0003, 1'b0, 1'b0);
        send_fields(1'b0, 1'b0, 1'b0, 32'h0000_0006, 1'b0, 1'b0);
        send_fields(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        enc_pos   = 2'd2;
        btn_level = 1'b1;

        // Random phases over defaults, extremes and zero settings.
        run_phase(1'b0, 8'd20,  16'd800,   16'd180,   16'd70,    3'd4, 0,  0,  200);
        run_phase(1'b1, 8'd1,   16'd1,     16'd1,     16'd65535, 3'd7, 80, 0,  200);
        run_phase(1'b0, 8'd255, 16'd65535, 16'd65535, 16'd1,     3'd1, 0,  80, 500);
        run_phase(1'b1, 8'd0,   16'd0,     16'd0,     16'd0,     3'd0, 6,  6,  200);
        run_phase(1'b0, 8'd5,   16'd300,   16'd50,    16'd200,   3'd7, 0,  0,  150);

        // Lowered max speed, with the result side held off so the input backs up.
        drain_block();
        apply_settings(1'b0, 8'd3, 16'd100, 16'd20, 16'd100, 3'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 400;
        send_random_samples(150);

        // Timestamps that cross the 32-bit wrap.
        drain_block();
        now_ms = 32'hFFFF_FF00;
        run_phase(1'b1, 8'd2, 16'd200, 16'd30, 16'd70, 3'd5, 6, 6, 200);

        drain_block();
        repeat (10) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
